[rtl/fbbs_pkg.sv]
package fbbs_pkg;

  // Item field widths
  localparam int unsigned EntryIdxW  = 6;
  localparam int unsigned EntryBlkW  = 16;
  localparam int unsigned StartSecW  = 23;
  localparam int unsigned SecCountW  = 7;
  localparam int unsigned AddrW      = 32;
  localparam int unsigned ShiftW     = 5;
  localparam int unsigned BadCountW  = 7;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 32;

  localparam int unsigned SectorShift = 9;
  localparam int unsigned ShiftMin    = 9;
  localparam int unsigned ShiftMax    = 20;
  localparam int unsigned WithinW     = ShiftMax;

  localparam logic [ShiftW-1:0] EraseShiftRst = ShiftW'(14);

  localparam logic ModeLoad = 1'b0;
  localparam logic ModeRead = 1'b1;

  localparam logic StatusOk      = 1'b0;
  localparam logic StatusTooLong = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgEraseShift = 2'd0,
    CfgPartOffset = 2'd1,
    CfgPartSize   = 2'd2,
    CfgBadCount   = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StIdle,
    StSetup,
    StWalk,
    StEmit
  } split_state_e;

  typedef enum logic [1:0] {
    WkIdle,
    WkRead,
    WkCmp,
    WkDone
  } walk_state_e;

  typedef struct packed {
    logic                 en;
    logic [EntryIdxW-1:0] index;
    logic [EntryBlkW-1:0] data;
  } tbl_wr_t;

  typedef struct packed {
    logic             start;
    logic [AddrW-1:0] block;
  } walk_ctl_t;

  typedef struct packed {
    logic             done;
    logic [AddrW-1:0] block;
  } walk_st_t;

endpackage

[rtl/fbbs_if.sv]
interface fbbs_in_if import fbbs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [EntryIdxW-1:0] entry_index;
  logic [EntryBlkW-1:0] entry_block;
  logic [StartSecW-1:0] start_sector;
  logic [SecCountW-1:0] sector_count;

  modport source (output valid, mode, entry_index, entry_block, start_sector, sector_count,
                  input ready);
  modport sink (input valid, mode, entry_index, entry_block, start_sector, sector_count,
                output ready);
endinterface

interface fbbs_out_if import fbbs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [AddrW-1:0]     flash_address;
  logic [SecCountW-1:0] chunk_sectors;
  logic                 status;
  logic                 last;

  modport source (output valid, flash_address, chunk_sectors, status, last, input ready);
  modport sink (input valid, flash_address, chunk_sectors, status, last, output ready);
endinterface

interface fbbs_cfg_if import fbbs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/fbbs_walk.sv]
module fbbs_walk import fbbs_pkg::*; #(
  parameter int unsigned MAX_BAD = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [BadCountW-1:0] bad_count_i,
  input  tbl_wr_t              tbl_wr_i,
  input  walk_ctl_t            ctl_i,
  output walk_st_t             st_o
);

  localparam int unsigned AW = (MAX_BAD > 1) ? $clog2(MAX_BAD) : 1;
  localparam int unsigned CW = $clog2(MAX_BAD + 1);

  logic [EntryBlkW-1:0] mem [MAX_BAD];
  logic [EntryBlkW-1:0] rdata_q;

  walk_state_e      state_q, state_d;
  logic [CW-1:0]    idx_q, idx_inc, nbad;
  logic [AddrW-1:0] blk_q;
  logic             stop, advance;

  always_comb begin
    if (32'(bad_count_i) > 32'(MAX_BAD)) begin
      nbad = CW'(MAX_BAD);
    end else begin
      nbad = CW'(bad_count_i);
    end
  end

  assign idx_inc = idx_q + CW'(1);
  assign stop    = 32'(rdata_q) > blk_q;

  // Bad block table: one write port from the load items, one registered read for the walk
  always_ff @(posedge clk_i) begin
    if (tbl_wr_i.en && (32'(tbl_wr_i.index) < 32'(MAX_BAD))) begin
      mem[AW'(tbl_wr_i.index)] <= tbl_wr_i.data;
    end
    rdata_q <= mem[idx_q[AW-1:0]];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      WkIdle: begin
        if (ctl_i.start) begin
          state_d = (nbad == '0) ? WkDone : WkRead;
        end
      end
      WkRead: state_d = WkCmp;
      WkCmp: begin
        if (stop || (idx_inc == nbad)) begin
          state_d = WkDone;
        end else begin
          state_d = WkRead;
        end
      end
      WkDone:  state_d = WkIdle;
      default: state_d = WkIdle;
    endcase
  end

  always_comb begin
    advance     = (state_q == WkCmp) && !stop;
    st_o.done   = (state_q == WkDone);
    st_o.block  = blk_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WkIdle;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (ctl_i.start && (state_q == WkIdle)) begin
        idx_q <= '0;
      end else if (advance) begin
        idx_q <= idx_inc;
      end
    end
  end

  // Step the block past each entry that is not above it
  always_ff @(posedge clk_i) begin
    if (ctl_i.start && (state_q == WkIdle)) begin
      blk_q <= ctl_i.block;
    end else if (advance) begin
      blk_q <= blk_q + AddrW'(1);
    end
  end

endmodule

[rtl/flash_bad_block_skip_read_splitter.sv]
// Splits a partition read request (start sector, sector count) into one result per erase
// block, each with the physical flash byte address and the sector count of that chunk,
// skipping the bad blocks of a table loaded with mode 0 items. A read item is accepted,
// then each chunk takes a setup step, a table walk of a read and a compare step for each
// entry examined plus a done step, and an emit step that waits until the output register
// is free. The walk reads the table one entry at a time; the entries examined are those
// at or below the block plus the first one above it, never more than the bad count. An
// oversized request goes from its accept straight to the emit step and puts its single
// error result in the output register. Ready is low from the accept of a nonzero read until
// its last result sits in the output register.
module flash_bad_block_skip_read_splitter import fbbs_pkg::*; #(
  parameter int unsigned MAX_BAD     = 64,
  parameter int unsigned MAX_SECTORS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  fbbs_in_if.sink    req_i,
  fbbs_out_if.source res_o,
  fbbs_cfg_if.sink   cfg_i
);

  localparam int unsigned RW = $clog2(MAX_SECTORS * 512 + 1);

  // Configuration registers
  logic [ShiftW-1:0]    erase_shift_q;
  logic [AddrW-1:0]     part_offset_q;
  logic [AddrW-1:0]     part_size_q;
  logic [BadCountW-1:0] bad_count_q;

  split_state_e state_q, state_d;

  logic              err_q;
  logic [AddrW-1:0]  pos_q;
  logic [RW-1:0]     remain_q, len_q;
  logic [ShiftW-1:0] shift_q;
  logic [WithinW-1:0] within_q;

  logic                 out_valid_q;
  logic [AddrW-1:0]     out_addr_q;
  logic [SecCountW-1:0] out_secs_q;
  logic                 out_status_q;
  logic                 out_last_q;

  logic                 accept, is_read, out_free, emit;
  logic [SecCountW-1:0] count_sat;
  logic [RW-1:0]        remain_new;
  logic                 too_long;
  logic [ShiftW-1:0]    shift_clamp;
  logic [AddrW-1:0]     mask, blk_offs, len_full;
  logic [RW-1:0]        len_new;
  logic                 last_chunk;

  tbl_wr_t   tbl_wr;
  walk_ctl_t walk_ctl;
  walk_st_t  walk_st;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      erase_shift_q <= EraseShiftRst;
      part_offset_q <= '0;
      part_size_q   <= '0;
      bad_count_q   <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_reg_e'(cfg_i.index))
        CfgEraseShift: erase_shift_q <= cfg_i.data[ShiftW-1:0];
        CfgPartOffset: part_offset_q <= cfg_i.data[AddrW-1:0];
        CfgPartSize:   part_size_q   <= cfg_i.data[AddrW-1:0];
        CfgBadCount:   bad_count_q   <= cfg_i.data[BadCountW-1:0];
        default: ;
      endcase
    end
  end

  // Request decode at accept
  always_comb begin
    if (32'(req_i.sector_count) > 32'(MAX_SECTORS)) begin
      count_sat = SecCountW'(MAX_SECTORS);
    end else begin
      count_sat = req_i.sector_count;
    end
    remain_new = RW'(count_sat) << SectorShift;
    too_long   = 32'(remain_new) > part_size_q;
    if (32'(erase_shift_q) < 32'(ShiftMin)) begin
      shift_clamp = ShiftW'(ShiftMin);
    end else if (32'(erase_shift_q) > 32'(ShiftMax)) begin
      shift_clamp = ShiftW'(ShiftMax);
    end else begin
      shift_clamp = erase_shift_q;
    end
  end

  // Chunk setup: block, offset within the block, and clipped length
  always_comb begin
    mask     = (AddrW'(1) << shift_q) - AddrW'(1);
    blk_offs = pos_q & mask;
    len_full = (AddrW'(1) << shift_q) - blk_offs;
    if (len_full > 32'(remain_q)) begin
      len_new = remain_q;
    end else begin
      len_new = RW'(len_full);
    end
  end

  assign accept     = req_i.valid && req_i.ready;
  assign is_read    = (req_i.mode == ModeRead);
  assign out_free   = !out_valid_q || res_o.ready;
  assign last_chunk = (remain_q == len_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept && is_read && (count_sat != '0)) begin
          state_d = too_long ? StEmit : StSetup;
        end
      end
      StSetup: state_d = StWalk;
      StWalk: begin
        if (walk_st.done) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          state_d = (err_q || last_chunk) ? StIdle : StSetup;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    req_i.ready    = (state_q == StIdle);
    tbl_wr.en      = accept && (req_i.mode == ModeLoad);
    tbl_wr.index   = req_i.entry_index;
    tbl_wr.data    = req_i.entry_block;
    walk_ctl.start = (state_q == StSetup);
    walk_ctl.block = pos_q >> shift_q;
    emit           = (state_q == StEmit) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_read) begin
      err_q    <= too_long;
      remain_q <= remain_new;
      pos_q    <= AddrW'(req_i.start_sector) << SectorShift;
      shift_q  <= shift_clamp;
    end
    if (state_q == StSetup) begin
      within_q <= blk_offs[WithinW-1:0];
      len_q    <= len_new;
    end
    if (emit) begin
      remain_q <= remain_q - len_q;
      pos_q    <= pos_q + AddrW'(len_q);
      if (err_q) begin
        out_addr_q   <= '0;
        out_secs_q   <= '0;
        out_status_q <= StatusTooLong;
        out_last_q   <= 1'b1;
      end else begin
        // Low bits of the shifted block are zero, so OR in the offset
        out_addr_q   <= part_offset_q + ((walk_st.block << shift_q) | AddrW'(within_q));
        out_secs_q   <= SecCountW'(len_q >> SectorShift);
        out_status_q <= StatusOk;
        out_last_q   <= last_chunk;
      end
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.flash_address = out_addr_q;
  assign res_o.chunk_sectors = out_secs_q;
  assign res_o.status        = out_status_q;
  assign res_o.last          = out_last_q;

  fbbs_walk #(
    .MAX_BAD (MAX_BAD)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bad_count_i (bad_count_q),
    .tbl_wr_i    (tbl_wr),
    .ctl_i       (walk_ctl),
    .st_o        (walk_st)
  );

endmodule
